// ===== hdl/ax25_pkg.sv =====
// ----------------------------------------------------------------------------
// ax25_pkg
// Shared types, codes and constants of the AX.25 frame decoder.
// ----------------------------------------------------------------------------
package ax25_pkg;

  localparam int MAX_DIGIPEATERS_DEF = 8;
  localparam int MAX_FRAME_BYTES_DEF = 1024;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  CTRL_UI  = 8'h03;
  localparam int MIN_FRAME_BYTES = 16;

  typedef enum logic [1:0] {
    KIND_DEST = 2'd0,
    KIND_SRC  = 2'd1,
    KIND_DIGI = 2'd2,
    KIND_SUM  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_FCS_BAD  = 3'd2,
    ST_ADDR_BAD = 3'd3,
    ST_NO_CTRL  = 3'd4,
    ST_NO_PID   = 3'd5,
    ST_TOO_LONG = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FT_I = 2'd0,
    FT_S = 2'd1,
    FT_U = 2'd2
  } ftype_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [41:0] callsign;
    logic [2:0]  callsign_len;
    logic [7:0]  ssid_octet;
    logic [3:0]  ssid;
    logic [2:0]  status;
    logic [7:0]  control;
    logic [1:0]  frame_type;
    logic [7:0]  pid;
    logic [10:0] info_start;
    logic [10:0] info_count;
    logic        last_record;
  } out_item_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== hdl/ax25_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ax25_frame_decoder
// AX.25 frame decoder: CRC-16/X.25 check, address parsing and record readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one frame byte per request, flags removed, FCS
//   last, the final byte marked by frame_end. Address octets go into a
//   70-byte RAM as they arrive; the CRC runs one byte per cycle while bytes
//   arrive, two bytes behind the input.
//   After the last byte the block stalls its input for the readout: an
//   evaluation state, then per address record the RAM reads (one read port,
//   7 octets, registered read data) and the record's delivery, then the
//   summary record. A frame in error gives the summary record alone.
//   out_valid/out_stall carry the records from one output register; while
//   out_stall is high the record holds and the readout waits.
//   Reset (rst_n low, synchronous) clears all frame state; the RAM needs no
//   clearing, since entries are read only after the same frame wrote them.
//   Writes happen only during input; read data is used only during readout.
// ----------------------------------------------------------------------------
module ax25_frame_decoder #(
  parameter int MAX_DIGIPEATERS = ax25_pkg::MAX_DIGIPEATERS_DEF,
  parameter int MAX_FRAME_BYTES = ax25_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ax25_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ax25_pkg::out_item_t out_data
);

  import ax25_pkg::*;

  localparam int STORE = (2 + MAX_DIGIPEATERS) * 7;
  localparam int RAW   = $clog2(STORE);
  localparam int CW    = $clog2(MAX_FRAME_BYTES + 2);
  localparam int SAW   = $clog2(STORE + 1);
  localparam int LW    = ((CW > SAW) ? CW : SAW) + 1;
  localparam int ACW   = $clog2(MAX_DIGIPEATERS + 3);

  typedef enum logic [2:0] {
    S_IN, S_EVAL, S_READ, S_SEND, S_SUMW
  } state_t;

  state_t    state_r;
  logic [15:0] crc_r, held_r;
  logic [CW-1:0] cnt_r;
  logic [2:0] pos7_r;
  logic [ACW-1:0] rec_r, acnt_r, emit_r;
  logic [LW-1:0] alen_r;
  logic closed_r;
  logic [7:0] ctrl_r, pid_r;
  logic [RAW-1:0] raddr_r;
  logic [2:0] iss_r, col_r;
  logic rvld_r;
  logic [41:0] cs_r;
  logic [2:0] clen_r;
  out_item_t out_r;
  logic out_valid_r;

  logic in_acc;
  logic [7:0] b;
  logic [LW-1:0] i_ext, len_ext, body, off;
  logic we;
  logic [7:0] rdata;
  logic pid_used;
  status_t st;
  out_item_t sum;
  out_item_t arec;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IN);
  assign b       = in_data.frame_byte;
  assign i_ext   = LW'(cnt_r);
  assign len_ext = LW'(cnt_r);
  assign body    = len_ext - LW'(2);
  assign we      = in_acc && !closed_r && (i_ext < LW'(STORE));
  assign pid_used = !ctrl_r[0] || (ctrl_r == CTRL_UI);
  assign off     = alen_r + (pid_used ? LW'(2) : LW'(1));

  ax25_ram #(.WIDTH(8), .DEPTH(STORE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[RAW-1:0]),
    .wdata (b),
    .raddr (raddr_r),
    .rdata (rdata)
  );

  always_comb begin
    if (len_ext > LW'(MAX_FRAME_BYTES)) begin
      st = ST_TOO_LONG;
    end else if (len_ext < LW'(MIN_FRAME_BYTES)) begin
      st = ST_SHORT;
    end else if (~crc_r != {held_r[7:0], held_r[15:8]}) begin
      st = ST_FCS_BAD;
    end else if (!closed_r || alen_r > body) begin
      st = ST_ADDR_BAD;
    end else if (alen_r + LW'(1) > body) begin
      st = ST_NO_CTRL;
    end else if (pid_used && alen_r + LW'(2) > body) begin
      st = ST_NO_PID;
    end else begin
      st = ST_OK;
    end
    sum = '0;
    sum.record_kind = KIND_SUM;
    sum.status = st;
    sum.last_record = 1'b1;
    if (st == ST_OK) begin
      sum.control = ctrl_r;
      sum.frame_type = !ctrl_r[0] ? FT_I : (ctrl_r[1] ? FT_U : FT_S);
      sum.pid = pid_used ? pid_r : 8'h00;
      sum.info_start = off[10:0];
      sum.info_count = 11'(body - off);
    end
  end

  always_comb begin
    arec = '0;
    arec.record_kind = (emit_r == '0) ? KIND_DEST :
                       ((emit_r == ACW'(1)) ? KIND_SRC : KIND_DIGI);
    arec.callsign = cs_r;
    arec.callsign_len = clen_r;
    arec.ssid_octet = rdata;
    arec.ssid = rdata[4:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      crc_r <= CRC_INIT;
      held_r <= '0;
      cnt_r <= '0;
      pos7_r <= '0;
      rec_r <= '0;
      acnt_r <= '0;
      alen_r <= '0;
      closed_r <= 1'b0;
      ctrl_r <= '0;
      pid_r <= '0;
      emit_r <= '0;
      raddr_r <= '0;
      iss_r <= '0;
      col_r <= '0;
      rvld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IN: begin
          if (in_acc) begin
            if (cnt_r >= CW'(2)) begin
              crc_r <= crc_byte(crc_r, held_r[15:8]);
            end
            held_r <= {held_r[7:0], b};
            if (closed_r) begin
              if (i_ext == alen_r) begin
                ctrl_r <= b;
              end else if (i_ext == alen_r + LW'(1)) begin
                pid_r <= b;
              end
            end else if (i_ext < LW'(STORE)) begin
              if (pos7_r == 3'd6) begin
                pos7_r <= '0;
                rec_r <= rec_r + ACW'(1);
                if (i_ext >= LW'(13) && b[0]) begin
                  closed_r <= 1'b1;
                  acnt_r <= rec_r + ACW'(1);
                  alen_r <= i_ext + LW'(1);
                end
              end else begin
                pos7_r <= pos7_r + 3'd1;
              end
            end
            if (cnt_r <= CW'(MAX_FRAME_BYTES)) begin
              cnt_r <= cnt_r + CW'(1);
            end
            if (in_data.frame_end) begin
              state_r <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          raddr_r <= '0;
          iss_r <= '0;
          col_r <= '0;
          rvld_r <= 1'b0;
          emit_r <= '0;
          if (st == ST_OK) begin
            state_r <= S_READ;
          end else begin
            out_r <= sum;
            out_valid_r <= 1'b1;
            state_r <= S_SUMW;
          end
        end
        S_READ: begin
          rvld_r <= (iss_r < 3'd7);
          if (iss_r < 3'd7) begin
            raddr_r <= raddr_r + RAW'(1);
            iss_r <= iss_r + 3'd1;
          end
          if (rvld_r) begin
            col_r <= col_r + 3'd1;
            if (col_r < 3'd6) begin
              cs_r <= {cs_r[34:0], rdata[7:1]};
              // length is the position of the last non-space character; a leading space sets it to zero
              if (rdata[7:1] != 7'h20) begin
                clen_r <= col_r + 3'd1;
              end else if (col_r == 3'd0) begin
                clen_r <= 3'd0;
              end
            end else begin
              out_r <= arec;
              out_valid_r <= 1'b1;
              state_r <= S_SEND;
            end
          end
        end
        S_SEND: begin
          if (!out_stall) begin
            iss_r <= '0;
            col_r <= '0;
            rvld_r <= 1'b0;
            emit_r <= emit_r + ACW'(1);
            if (emit_r + ACW'(1) < acnt_r) begin
              out_valid_r <= 1'b0;
              state_r <= S_READ;
            end else begin
              out_r <= sum;
              state_r <= S_SUMW;
            end
          end
        end
        S_SUMW: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            crc_r <= CRC_INIT;
            held_r <= '0;
            cnt_r <= '0;
            pos7_r <= '0;
            rec_r <= '0;
            acnt_r <= '0;
            alen_r <= '0;
            closed_r <= 1'b0;
            ctrl_r <= '0;
            pid_r <= '0;
            emit_r <= '0;
            state_r <= S_IN;
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/ax25_ram.sv =====
// ----------------------------------------------------------------------------
// ax25_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ax25_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 70
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ax25_checker.sv =====
// ----------------------------------------------------------------------------
// ax25_checker
// Port-level assertions for the AX.25 frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ax25_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ax25_pkg::out_item_t out_data
);

  import ax25_pkg::*;

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while a record waits");

  a_last_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_record |-> out_data.record_kind == KIND_SUM)
    else $error("last record is not a summary");

  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind != KIND_SUM |-> out_data.status == ST_OK)
    else $error("address record carries a status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled record changed");

endmodule

bind ax25_frame_decoder ax25_checker u_ax25_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
